[hw/rtl/rti_pkg.sv]
// Shared types, constants and codes for the radial table interpolator.
// Used by every file of the block but rti_ram; depends on nothing.
package rti_pkg;

  localparam int TABLE_DEPTH = 8192;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int RAD_W       = 32;
  localparam int VAL_W       = 32;
  localparam int N_VAL       = 5;
  localparam int VALS_W      = VAL_W * N_VAL;
  localparam int LANE_W      = 3;
  localparam int CNT_W       = 14;
  localparam int CFG_IDX_W   = 2;
  localparam int EST_SCALE   = 5000;
  localparam int EST_W       = RAD_W + 13;
  localparam int FRAC_BITS   = 24;
  localparam int DIV_DEN_W   = RAD_W;
  localparam int DIV_NUM_W   = DIV_DEN_W + FRAC_BITS;
  localparam int QUO_W       = 30;
  localparam int DIV_CNT_W   = $clog2(QUO_W);
  localparam logic [QUO_W-1:0] FRAC_LIMIT = QUO_W'(1) << (QUO_W - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_RADIUS  = 2'd0,
    CFG_MAX_RADIUS  = 2'd1,
    CFG_ENTRY_COUNT = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_LATCH,
    OP_EST_MUL,
    OP_EST_DIV,
    OP_EST_LOAD,
    OP_RD_J,
    OP_STEP,
    OP_RD_LO,
    OP_CAP_LO,
    OP_CAP_HI,
    OP_FRAC_LOAD,
    OP_MUL,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic [LANE_W-1:0] lane;
  } dp_cmd_t;

  typedef struct packed {
    logic oos;
    logic div_done;
    logic walk_go;
    logic out_free;
  } dp_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EST_MUL,
    ST_EST_DIV,
    ST_EST_WAIT,
    ST_WALK_RD,
    ST_WALK_CMP,
    ST_CAP_LO,
    ST_CAP_HI,
    ST_FRAC_WAIT,
    ST_MUL,
    ST_DRAIN,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic                    is_load;
    logic [IDX_W-1:0]        entry_index;
    logic [RAD_W-1:0]        entry_radius;
    logic [VALS_W-1:0]       entry_vals;
    logic [RAD_W-1:0]        query_radius;
  } in_item_t;

endpackage

[hw/rtl/rti_if.sv]
// Valid/ready channel interfaces for query/load items and results.
// Depends on rti_pkg.
interface rti_in_if import rti_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic [IDX_W-1:0]        entry_index;
  logic [RAD_W-1:0]        entry_radius;
  logic signed [VAL_W-1:0] entry_pair_aa;
  logic signed [VAL_W-1:0] entry_pair_ab;
  logic signed [VAL_W-1:0] entry_pair_bb;
  logic signed [VAL_W-1:0] entry_dens_a;
  logic signed [VAL_W-1:0] entry_dens_b;
  logic [RAD_W-1:0]        query_radius;

  modport source (output valid, cmd, entry_index, entry_radius, entry_pair_aa, entry_pair_ab,
                  entry_pair_bb, entry_dens_a, entry_dens_b, query_radius, input ready);
  modport sink (input valid, cmd, entry_index, entry_radius, entry_pair_aa, entry_pair_ab,
                entry_pair_bb, entry_dens_a, entry_dens_b, query_radius, output ready);
endinterface

interface rti_out_if import rti_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    in_scope;
  logic [IDX_W-1:0]        upper_index;
  logic signed [VAL_W-1:0] pot_aa;
  logic signed [VAL_W-1:0] pot_ab;
  logic signed [VAL_W-1:0] pot_bb;
  logic signed [VAL_W-1:0] dens_a;
  logic signed [VAL_W-1:0] dens_b;

  modport source (output valid, in_scope, upper_index, pot_aa, pot_ab, pot_bb, dens_a, dens_b,
                  input ready);
  modport sink (input valid, in_scope, upper_index, pot_aa, pot_ab, pot_bb, dens_a, dens_b,
                output ready);
endinterface

[hw/rtl/rti_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module rti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

[hw/rtl/rti_div.sv]
// Restoring divider, one quotient bit per cycle, quotient saturated to FRAC_LIMIT.
// Depends on rti_pkg.
module rti_div import rti_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [QUO_W-1:0]     quo
);
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [QUO_W-1:0]     low_r, low_nxt;
  logic [QUO_W-1:0]     q_r, q_nxt;
  logic [DIV_DEN_W:0]   trial;
  logic                 ge;

  assign trial = {rem_r, low_r[QUO_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    ovf_nxt  = ovf_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    low_nxt  = low_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      ovf_nxt  = {(QUO_W + DIV_DEN_W - DIV_NUM_W)'(0), num} >= {den, QUO_W'(0)};
      rem_nxt  = DIV_DEN_W'(num[DIV_NUM_W-1:QUO_W]);
      low_nxt  = num[QUO_W-1:0];
      den_nxt  = den;
      cnt_nxt  = DIV_CNT_W'(QUO_W - 1);
    end else if (busy_r) begin
      if (ovf_r) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        rem_nxt = ge ? DIV_DEN_W'(trial - {1'b0, den_r}) : trial[DIV_DEN_W-1:0];
        low_nxt = {low_r[QUO_W-2:0], 1'b0};
        q_nxt   = {q_r[QUO_W-2:0], ge};
        if (cnt_r == '0) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    ovf_r <= ovf_nxt;
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    low_r <= low_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quo  = (ovf_r || q_r > FRAC_LIMIT) ? FRAC_LIMIT : q_r;
endmodule

[hw/rtl/rti_ctrl.sv]
// Sequencer for loads and queries: estimate, table walk, fraction, interpolation.
// Depends on rti_pkg; drives rti_dp through dp_cmd_t and reads dp_stat_t.
module rti_ctrl import rti_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_is_load,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);
  ctrl_state_t       state_r, state_nxt;
  logic [LANE_W-1:0] lane_r, lane_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      lane_r  <= '0;
    end else begin
      state_r <= state_nxt;
      lane_r  <= lane_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    lane_nxt  = lane_r;
    in_ready  = 1'b0;
    cmd.op    = OP_NONE;
    cmd.lane  = lane_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_is_load) begin
            cmd.op = OP_LOAD;
          end else begin
            cmd.op    = OP_LATCH;
            state_nxt = ST_EST_MUL;
          end
        end
      end
      ST_EST_MUL: begin
        cmd.op    = OP_EST_MUL;
        state_nxt = stat.oos ? ST_EMIT : ST_EST_DIV;
      end
      ST_EST_DIV: begin
        cmd.op    = OP_EST_DIV;
        state_nxt = ST_EST_WAIT;
      end
      ST_EST_WAIT: begin
        if (stat.div_done) begin
          cmd.op    = OP_EST_LOAD;
          state_nxt = ST_WALK_RD;
        end
      end
      ST_WALK_RD: begin
        cmd.op    = OP_RD_J;
        state_nxt = ST_WALK_CMP;
      end
      ST_WALK_CMP: begin
        if (stat.walk_go) begin
          cmd.op = OP_STEP;
        end else begin
          cmd.op    = OP_RD_LO;
          state_nxt = ST_CAP_LO;
        end
      end
      ST_CAP_LO: begin
        cmd.op    = OP_CAP_LO;
        state_nxt = ST_CAP_HI;
      end
      ST_CAP_HI: begin
        cmd.op    = OP_CAP_HI;
        state_nxt = ST_FRAC_WAIT;
      end
      ST_FRAC_WAIT: begin
        if (stat.div_done) begin
          cmd.op    = OP_FRAC_LOAD;
          lane_nxt  = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.op = OP_MUL;
        if (lane_r == LANE_W'(N_VAL - 1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          lane_nxt = lane_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.op    = OP_EMIT;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end
endmodule

[hw/rtl/rti_dp.sv]
// Datapath: configuration, table memories, estimate, walk compare, fraction
// divider and per-value multiply, round and saturate. Depends on rti_pkg,
// rti_ram and rti_div.
module rti_dp import rti_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_cmd_t                 cmd,
  output dp_stat_t                stat,
  input  in_item_t                item,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [RAD_W-1:0]        cfg_wdata,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_in_scope,
  output logic [IDX_W-1:0]        out_upper_index,
  output logic [VALS_W-1:0]       out_vals
);
  logic [RAD_W-1:0]        min_r, max_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [RAD_W-1:0]        r_r;
  logic [IDX_W-1:0]        j_r;
  logic [EST_W-1:0]        est_prod_r;
  logic [RAD_W-1:0]        rad_hi_r, rad_lo_r;
  logic [VALS_W-1:0]       lo_r, hi_r;
  logic                    same_r, neg_r;
  logic signed [QUO_W:0]   frac_r;
  logic signed [63:0]      prod_r;
  logic signed [VAL_W-1:0] y0_r, y1_r;
  logic                    mul_v_r;
  logic [LANE_W-1:0]       mul_lane_r;
  logic [VAL_W-1:0]        res_r [N_VAL];
  logic                    out_valid_r;
  logic                    out_scope_r;
  logic [IDX_W-1:0]        out_idx_r;
  logic [VALS_W-1:0]       out_vals_r;

  logic [CNT_W-1:0]        n_eff;
  logic [IDX_W-1:0]        n_m1;
  logic                    oos;
  logic [IDX_W-1:0]        raddr;
  logic [RAD_W-1:0]        rad_q;
  logic [VALS_W-1:0]       vals_q;
  logic                    wr_en;
  logic                    div_start, div_done;
  logic [DIV_NUM_W-1:0]    div_num;
  logic [DIV_DEN_W-1:0]    div_den;
  logic [QUO_W-1:0]        quo;
  logic signed [RAD_W:0]   t_s, dx_s;
  logic [RAD_W-1:0]        abs_t, abs_dx;
  logic signed [VAL_W:0]   diff;
  logic signed [63:0]      prod_nxt, rnd;
  logic signed [39:0]      sh;
  logic signed [40:0]      ysum;
  logic [VAL_W-1:0]        y_sat;
  logic                    out_free;

  always_comb begin
    if (cnt_r < CNT_W'(2)) begin
      n_eff = CNT_W'(2);
    end else if (32'(cnt_r) > TABLE_DEPTH) begin
      n_eff = CNT_W'(TABLE_DEPTH);
    end else begin
      n_eff = cnt_r;
    end
  end
  assign n_m1 = IDX_W'(n_eff - 1'b1);
  assign oos  = (r_r < min_r) || (r_r > max_r);

  assign wr_en = (cmd.op == OP_LOAD) && (32'(item.entry_index) < TABLE_DEPTH);

  always_comb begin
    case (cmd.op)
      OP_STEP:  raddr = j_r + 1'b1;
      OP_RD_LO: raddr = j_r - 1'b1;
      default:  raddr = j_r;
    endcase
  end

  rti_ram #(.WIDTH(RAD_W), .DEPTH(TABLE_DEPTH)) u_rad_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (item.entry_index),
    .wdata (item.entry_radius),
    .raddr (raddr),
    .rdata (rad_q)
  );

  rti_ram #(.WIDTH(VALS_W), .DEPTH(TABLE_DEPTH)) u_val_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (item.entry_index),
    .wdata (item.entry_vals),
    .raddr (raddr),
    .rdata (vals_q)
  );

  assign t_s    = $signed({1'b0, r_r}) - $signed({1'b0, rad_lo_r});
  assign dx_s   = $signed({1'b0, rad_hi_r}) - $signed({1'b0, rad_lo_r});
  assign abs_t  = t_s[RAD_W] ? RAD_W'(-t_s) : t_s[RAD_W-1:0];
  assign abs_dx = dx_s[RAD_W] ? RAD_W'(-dx_s) : dx_s[RAD_W-1:0];

  assign div_start = (cmd.op == OP_EST_DIV) || (cmd.op == OP_CAP_HI);
  assign div_num   = (cmd.op == OP_EST_DIV) ? DIV_NUM_W'(est_prod_r)
                                            : {abs_t, FRAC_BITS'(0)};
  assign div_den   = (cmd.op == OP_EST_DIV) ? (max_r - min_r) : abs_dx;

  rti_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  assign diff     = $signed({hi_r[cmd.lane*VAL_W + VAL_W-1], hi_r[cmd.lane*VAL_W +: VAL_W]})
                  - $signed({lo_r[cmd.lane*VAL_W + VAL_W-1], lo_r[cmd.lane*VAL_W +: VAL_W]});
  assign prod_nxt = diff * frac_r;

  assign rnd  = prod_r + 64'sd8388608;
  assign sh   = rnd[63:FRAC_BITS];
  assign ysum = {{9{y0_r[VAL_W-1]}}, y0_r} + {sh[39], sh};

  always_comb begin
    if (same_r) begin
      y_sat = y1_r;
    end else if (ysum > 41'sd2147483647) begin
      y_sat = {1'b0, {(VAL_W-1){1'b1}}};
    end else if (ysum < -41'sd2147483648) begin
      y_sat = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      y_sat = ysum[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r       <= '0;
      max_r       <= '1;
      cnt_r       <= CNT_W'(TABLE_DEPTH);
      mul_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_MIN_RADIUS:  min_r <= cfg_wdata;
          CFG_MAX_RADIUS:  max_r <= cfg_wdata;
          CFG_ENTRY_COUNT: cnt_r <= cfg_wdata[CNT_W-1:0];
          default: begin
          end
        endcase
      end
      mul_v_r <= (cmd.op == OP_MUL);
      if (cmd.op == OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH:   r_r <= item.query_radius;
      OP_EST_MUL: est_prod_r <= EST_W'(r_r - min_r) * EST_W'(EST_SCALE);
      OP_EST_LOAD: begin
        if (min_r == max_r || quo == '0) begin
          j_r <= IDX_W'(1);
        end else if (32'(quo) > 32'(n_m1)) begin
          j_r <= n_m1;
        end else begin
          j_r <= quo[IDX_W-1:0];
        end
      end
      OP_STEP:  j_r <= j_r + 1'b1;
      OP_RD_LO: rad_hi_r <= rad_q;
      OP_CAP_LO: begin
        rad_lo_r <= rad_q;
        lo_r     <= vals_q;
      end
      OP_CAP_HI: begin
        hi_r   <= vals_q;
        same_r <= (dx_s == '0);
        neg_r  <= t_s[RAD_W] ^ dx_s[RAD_W];
      end
      OP_FRAC_LOAD: frac_r <= neg_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
      OP_MUL: begin
        prod_r     <= prod_nxt;
        y0_r       <= lo_r[cmd.lane*VAL_W +: VAL_W];
        y1_r       <= hi_r[cmd.lane*VAL_W +: VAL_W];
        mul_lane_r <= cmd.lane;
      end
      OP_EMIT: begin
        out_scope_r <= !oos;
        out_idx_r   <= oos ? '0 : j_r;
        for (int i = 0; i < N_VAL; i++) begin
          out_vals_r[i*VAL_W +: VAL_W] <= oos ? '0 : res_r[i];
        end
      end
      default: begin
      end
    endcase
    if (mul_v_r) begin
      res_r[mul_lane_r] <= y_sat;
    end
  end

  assign out_free      = !out_valid_r || out_ready;
  assign stat.oos      = oos;
  assign stat.div_done = div_done;
  assign stat.walk_go  = (j_r < n_m1) && (rad_q < r_r);
  assign stat.out_free = out_free;

  assign out_valid       = out_valid_r;
  assign out_in_scope    = out_scope_r;
  assign out_upper_index = out_idx_r;
  assign out_vals        = out_vals_r;

`ifndef SYNTHESIS
  a_idx_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_scope_r |-> out_idx_r != '0)
    else $error("in-scope result with upper index zero");
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_STEP |=> j_r <= n_m1)
    else $error("table walk ran past the last entry in use");
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_EMIT |=> out_valid_r)
    else $error("emitted result not presented");
`endif
endmodule

[hw/rtl/radial_table_interpolator_core.sv]
// Load: loads may follow each other every cycle while no query is in progress.
// Query: s forward walk steps (one table read each) between the estimate and fraction divisions
// in rti_div, which take most of the query; out of scope, the divisions and the walk are skipped.
// Synchronous active-low reset clears control and resets configuration to defaults; table contents
// are not cleared and hold nothing defined until loaded.
// Top level; depends on rti_pkg, rti_if, rti_ctrl and rti_dp.
module radial_table_interpolator_core import rti_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  rti_in_if.sink               in_ch,
  rti_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RAD_W-1:0]     cfg_wdata
);
  dp_cmd_t           cmd;
  dp_stat_t          stat;
  in_item_t          item;
  logic [VALS_W-1:0] vals;

  assign item.is_load      = in_ch.cmd;
  assign item.entry_index  = in_ch.entry_index;
  assign item.entry_radius = in_ch.entry_radius;
  assign item.entry_vals   = {in_ch.entry_dens_b, in_ch.entry_dens_a, in_ch.entry_pair_bb,
                              in_ch.entry_pair_ab, in_ch.entry_pair_aa};
  assign item.query_radius = in_ch.query_radius;

  rti_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_is_load (item.is_load),
    .in_ready   (in_ch.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  rti_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .item            (item),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_in_scope    (out_ch.in_scope),
    .out_upper_index (out_ch.upper_index),
    .out_vals        (vals)
  );

  assign out_ch.pot_aa = vals[0*VAL_W +: VAL_W];
  assign out_ch.pot_ab = vals[1*VAL_W +: VAL_W];
  assign out_ch.pot_bb = vals[2*VAL_W +: VAL_W];
  assign out_ch.dens_a = vals[3*VAL_W +: VAL_W];
  assign out_ch.dens_b = vals[4*VAL_W +: VAL_W];
endmodule
